// File: hdl/rwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_pkg: shared types and constants for the running window average
// Sample, sum and count widths, plus the request word for the divider.
// ----------------------------------------------------------------------------
package rwa_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int WINDOW_LENGTH = 64;

  // fill count runs 0..WINDOW_LENGTH inclusive
  localparam int COUNT_W = $clog2(WINDOW_LENGTH + 1);
  // sum of a full window of samples never overflows this width
  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LENGTH);
  // one quotient bit per divider step
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [COUNT_W-1:0]         count_t;

  // start request handed to the divider
  typedef struct packed {
    logic   start;
    sum_t   dividend;
    count_t divisor;
  } div_req_t;

endpackage

// File: hdl/rwa_tap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_tap_cell: one stage of the sample delay line
// Holds one sample and takes its neighbor's sample on each shift.
// ----------------------------------------------------------------------------
module rwa_tap_cell (
  input  logic            clk,
  input  logic            shift,
  input  rwa_pkg::sample_t din,
  output rwa_pkg::sample_t dout
);
  import rwa_pkg::*;

  sample_t held;

  // payload only, no reset: a stage is never read before it is filled
  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule

// File: hdl/rwa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_divider: signed sum divided by the fill count
// Restoring divide, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module rwa_divider (
  input  logic              clk,
  input  logic              rst,
  input  rwa_pkg::div_req_t req,
  output logic              req_ready,
  output logic              done,
  input  logic              take,
  output rwa_pkg::sample_t  quotient
);
  import rwa_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_DONE = 2'd2;

  logic [1:0]       state;
  logic [STEP_W-1:0] step;
  logic [COUNT_W-1:0] rem;
  logic [SUM_W-1:0]   quo;
  count_t             divisor;
  logic               neg;

  logic [COUNT_W:0]   trial;
  logic               fits;
  logic [COUNT_W:0]   trial_diff;
  logic [SUM_W-1:0]   signed_quo;

  // one restoring step
  always_comb begin
    trial      = {rem, quo[SUM_W-1]};
    fits       = trial >= {1'b0, divisor};
    trial_diff = trial - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            state <= D_RUN;
            step  <= '0;
          end
        end
        D_RUN: begin
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= D_DONE;
          end
        end
        D_DONE: begin
          if (take) begin
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  // datapath: work on the magnitude, fix the sign at the end
  always_ff @(posedge clk) begin
    if (state == D_IDLE && req.start) begin
      neg     <= req.dividend[SUM_W-1];
      quo     <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
      rem     <= '0;
      divisor <= req.divisor;
    end else if (state == D_RUN) begin
      rem <= fits ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign signed_quo = neg ? (~quo + 1'b1) : quo;
  assign quotient   = signed_quo[SAMPLE_W-1:0];
  assign req_ready  = (state == D_IDLE);
  assign done       = (state == D_DONE);

endmodule

// File: hdl/running_window_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_window_average: mean of the most recent 64 samples
// Delay line of tap cells, running sum, and a serial divider by fill count.
// ----------------------------------------------------------------------------
//  channel   handshake             word
//  input     in_valid / in_ready   sample  (16b signed)
//  output    out_valid / out_ready average (16b signed)
//
//  For each word, the accept edge updates the sum and the delay line and
//  starts the divider, which then works out the quotient one bit per step;
//  the output register then takes the quotient.
//  in_ready is high while the divider is idle; a word may be accepted while
//  the previous average still waits in the output register.
//  A stalled output holds the finished quotient in the divider.
//  Synchronous reset clears the sum, fill count and handshake state.
// ----------------------------------------------------------------------------
module running_window_average (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rwa_pkg::sample_t sample,
  output logic             out_valid,
  input  logic             out_ready,
  output rwa_pkg::sample_t average
);
  import rwa_pkg::*;

  sample_t  taps [WINDOW_LENGTH];
  sum_t     running_sum;
  sum_t     running_sum_next;
  count_t   filled_count;
  count_t   filled_count_next;
  logic     accept;
  logic     full;
  div_req_t div_req;
  logic     div_ready;
  logic     div_done;
  logic     div_take;
  sample_t  div_quotient;

  assign accept = in_valid && in_ready;
  assign full   = (filled_count == COUNT_W'(WINDOW_LENGTH));

  // delay line: each cell takes its neighbor's sample on accept
  for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      rwa_tap_cell u_cell (.clk(clk), .shift(accept), .din(sample), .dout(taps[i]));
    end else begin : g_body
      rwa_tap_cell u_cell (.clk(clk), .shift(accept), .din(taps[i-1]), .dout(taps[i]));
    end
  end

  // sum recurrence: drop the oldest once full, add the new one
  always_comb begin
    running_sum_next = running_sum + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    if (full) begin
      running_sum_next = running_sum_next -
        {{(SUM_W-SAMPLE_W){taps[WINDOW_LENGTH-1][SAMPLE_W-1]}}, taps[WINDOW_LENGTH-1]};
    end
    filled_count_next = full ? filled_count : filled_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      filled_count <= '0;
    end else if (accept) begin
      running_sum  <= running_sum_next;
      filled_count <= filled_count_next;
    end
  end

  // divider start
  assign div_req.start    = accept;
  assign div_req.dividend = running_sum_next;
  assign div_req.divisor  = filled_count_next;
  assign in_ready         = div_ready;

  rwa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .req_ready(div_ready),
    .done     (div_done),
    .take     (div_take),
    .quotient (div_quotient)
  );

  // output register
  assign div_take = div_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      average <= div_quotient;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken again while divide in progress");

  a_full_stays: assert property (@(posedge clk) disable iff (rst)
    accept && full |=> full)
    else $error("fill count left full window");

  a_take_loads_output: assert property (@(posedge clk) disable iff (rst)
    div_take |=> out_valid)
    else $error("quotient taken but no output word");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    accept && !full |=> filled_count == $past(filled_count) + 1'b1)
    else $error("fill count did not advance during warm-up");

endmodule
